[rtl/ledf_pkg.sv]
// ============================================================================
// ledf_pkg - shared types and constants of the event deframer
// Phase encoding, the result record, the core status record and the byte
// codes that the frame and event parser looks for.
// ============================================================================
package ledf_pkg;

    // Number of bytes in the big-endian length field at the head of a frame.
    localparam int LEN_BYTES = 8;
    localparam int HDR_CNT_W = $clog2(LEN_BYTES);

    localparam int BYTE_W = 8;
    localparam int WORD_W = 64;

    // Largest legal payload length: 2^64 - 9.
    localparam logic [WORD_W-1:0] MAX_LEN = 64'hFFFF_FFFF_FFFF_FFF7;

    // Decimal accumulation: the value times ten must stay within 64 bits.
    localparam logic [WORD_W-1:0] ACC_LIMIT        = 64'h1999_9999_9999_9999;
    localparam logic [3:0]        LAST_DIGIT_LIMIT = 4'd5;

    // Byte codes.
    localparam logic [BYTE_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PATH,
        PH_NUM_LEAD,
        PH_NUM_SIGNED,
        PH_NUM_DIGITS,
        PH_JSON,
        PH_DEAD
    } t_phase;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              byte_is_json;
        logic [WORD_W-1:0] callback_id;
        logic              callback_valid;
        logic              event_done;
        logic              fatal_error;
    } t_result;

    // Status of the parser core seen by the top level.
    typedef struct packed {
        logic dead;
        logic in_header;
    } t_core_status;

endpackage

[rtl/ledf_in_stage.sv]
// ============================================================================
// ledf_in_stage - input byte register
// Holds one received byte until the parser core takes it, so the upstream
// side sees ready while the byte in hand is being consumed.
// ============================================================================
module ledf_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ledf_pkg::BYTE_W-1:0]    i_byte,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [ledf_pkg::BYTE_W-1:0]    o_byte,
    input  logic                           i_take
);

    logic                        r_valid;
    logic                        n_valid;
    logic [ledf_pkg::BYTE_W-1:0] r_byte;
    logic                        accept;

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[rtl/ledf_core.sv]
// ============================================================================
// ledf_core - frame and event parser
// Holds the parse state and works out, for one byte, the next state and the
// result record in a single pass of combinational logic.
// ============================================================================
module ledf_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ledf_pkg::BYTE_W-1:0]    i_byte,
    output ledf_pkg::t_result              o_result,
    output ledf_pkg::t_core_status         o_status
);

    ledf_pkg::t_phase                       r_phase;
    ledf_pkg::t_phase                       n_phase;
    logic [ledf_pkg::HDR_CNT_W-1:0]         r_hdr_cnt;
    logic [ledf_pkg::HDR_CNT_W-1:0]         n_hdr_cnt;
    logic [ledf_pkg::WORD_W-1:0]            r_remaining;
    logic [ledf_pkg::WORD_W-1:0]            n_remaining;
    logic [ledf_pkg::WORD_W-1:0]            r_acc;
    logic [ledf_pkg::WORD_W-1:0]            n_acc;
    logic                                   r_neg;
    logic                                   n_neg;
    logic                                   r_ovf;
    logic                                   n_ovf;
    logic                                   r_trunc;
    logic                                   n_trunc;

    logic                                   is_digit;
    logic                                   is_blank;
    logic                                   is_sign;
    logic [3:0]                             digit;
    logic [ledf_pkg::WORD_W-1:0]            hdr_len;
    logic                                   hdr_last;
    logic                                   len_bad;
    logic                                   last;
    logic                                   ovf_now;
    logic [ledf_pkg::WORD_W-1:0]            acc_digit;
    logic                                   fatal;

    // Byte classes and the arithmetic that any phase may need.
    always_comb begin
        is_digit  = (i_byte >= ledf_pkg::CHAR_ZERO) && (i_byte <= ledf_pkg::CHAR_NINE);
        is_blank  = (i_byte == ledf_pkg::CHAR_SPACE) ||
                    ((i_byte >= ledf_pkg::CHAR_TAB) && (i_byte <= ledf_pkg::CHAR_CR));
        is_sign   = (i_byte == ledf_pkg::CHAR_MINUS) || (i_byte == ledf_pkg::CHAR_PLUS);
        digit     = 4'(i_byte - ledf_pkg::CHAR_ZERO);
        hdr_len   = {r_remaining[ledf_pkg::WORD_W-ledf_pkg::BYTE_W-1:0], i_byte};
        hdr_last  = (r_hdr_cnt == ledf_pkg::HDR_CNT_W'(ledf_pkg::LEN_BYTES - 1));
        len_bad   = (hdr_len == '0) || (hdr_len > ledf_pkg::MAX_LEN);
        last      = (r_remaining == ledf_pkg::WORD_W'(1));
        ovf_now   = r_ovf || (r_acc > ledf_pkg::ACC_LIMIT) ||
                    ((r_acc == ledf_pkg::ACC_LIMIT) && (digit > ledf_pkg::LAST_DIGIT_LIMIT));
        // Times ten as two shifted copies.
        acc_digit = (r_acc << 3) + (r_acc << 1) + ledf_pkg::WORD_W'(digit);
    end

    // Format faults. Running out of payload before the json part is reached
    // is a fault in every phase before it.
    always_comb begin
        fatal = 1'b0;
        unique case (r_phase)
            ledf_pkg::PH_HEADER:     fatal = hdr_last && len_bad;
            ledf_pkg::PH_PATH:       fatal = (i_byte == ledf_pkg::CHAR_NUL) || last;
            ledf_pkg::PH_NUM_LEAD:   fatal = !(is_blank || is_sign || is_digit) || last;
            ledf_pkg::PH_NUM_SIGNED: fatal = !is_digit || last;
            ledf_pkg::PH_NUM_DIGITS: fatal = (i_byte != ledf_pkg::CHAR_EQUALS) &&
                                             (!is_digit || last);
            default:                 fatal = 1'b0;
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            if (fatal) begin
                n_phase = ledf_pkg::PH_DEAD;
            end else begin
                unique case (r_phase)
                    ledf_pkg::PH_HEADER: begin
                        if (hdr_last) n_phase = ledf_pkg::PH_PATH;
                    end
                    ledf_pkg::PH_PATH: begin
                        if (i_byte == ledf_pkg::CHAR_COLON) n_phase = ledf_pkg::PH_NUM_LEAD;
                    end
                    ledf_pkg::PH_NUM_LEAD: begin
                        if (is_sign) begin
                            n_phase = ledf_pkg::PH_NUM_SIGNED;
                        end else if (is_digit) begin
                            n_phase = ledf_pkg::PH_NUM_DIGITS;
                        end
                    end
                    ledf_pkg::PH_NUM_SIGNED: n_phase = ledf_pkg::PH_NUM_DIGITS;
                    ledf_pkg::PH_NUM_DIGITS: begin
                        if (i_byte == ledf_pkg::CHAR_EQUALS) begin
                            n_phase = last ? ledf_pkg::PH_HEADER : ledf_pkg::PH_JSON;
                        end
                    end
                    ledf_pkg::PH_JSON: begin
                        if (last) n_phase = ledf_pkg::PH_HEADER;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // Counters and event registers.
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_trunc     = r_trunc;
        if (i_step && !fatal) begin
            case (r_phase) inside
                ledf_pkg::PH_HEADER: begin
                    n_remaining = hdr_len;
                    n_hdr_cnt   = hdr_last ? '0 : r_hdr_cnt + 1'b1;
                    if (hdr_last) begin
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_ovf   = 1'b0;
                        n_trunc = 1'b0;
                    end
                end
                ledf_pkg::PH_PATH, ledf_pkg::PH_NUM_LEAD, ledf_pkg::PH_NUM_SIGNED,
                ledf_pkg::PH_NUM_DIGITS, ledf_pkg::PH_JSON: begin
                    n_remaining = r_remaining - 1'b1;
                    if ((r_phase == ledf_pkg::PH_NUM_LEAD) &&
                        (i_byte == ledf_pkg::CHAR_MINUS)) begin
                        n_neg = 1'b1;
                    end
                    if ((r_phase != ledf_pkg::PH_PATH) && (r_phase != ledf_pkg::PH_JSON) &&
                        is_digit) begin
                        n_ovf = ovf_now;
                        if (!ovf_now) n_acc = acc_digit;
                    end
                    if ((r_phase == ledf_pkg::PH_JSON) && (i_byte == ledf_pkg::CHAR_NUL)) begin
                        n_trunc = 1'b1;
                    end
                    if (last) begin
                        n_hdr_cnt = '0;
                        n_acc     = '0;
                        n_neg     = 1'b0;
                        n_ovf     = 1'b0;
                        n_trunc   = 1'b0;
                    end
                end
                default: begin
                    n_remaining = r_remaining;
                end
            endcase
        end
    end

    // Result record for the byte in hand.
    always_comb begin
        o_result = '0;
        if (fatal) begin
            o_result.fatal_error = 1'b1;
        end else begin
            unique case (r_phase)
                ledf_pkg::PH_PATH: begin
                    if (i_byte != ledf_pkg::CHAR_COLON) begin
                        o_result.payload_byte = i_byte;
                        o_result.byte_valid   = 1'b1;
                    end
                end
                ledf_pkg::PH_NUM_DIGITS: begin
                    if (i_byte == ledf_pkg::CHAR_EQUALS) begin
                        o_result.callback_valid = 1'b1;
                        o_result.event_done     = last;
                        if (r_ovf) begin
                            o_result.callback_id = '1;
                        end else if (r_neg) begin
                            o_result.callback_id = '0 - r_acc;
                        end else begin
                            o_result.callback_id = r_acc;
                        end
                    end
                end
                ledf_pkg::PH_JSON: begin
                    o_result.event_done = last;
                    if (!r_trunc && (i_byte != ledf_pkg::CHAR_NUL)) begin
                        o_result.payload_byte = i_byte;
                        o_result.byte_valid   = 1'b1;
                        o_result.byte_is_json = 1'b1;
                    end
                end
                default: o_result = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ledf_pkg::PH_HEADER;
            r_hdr_cnt   <= '0;
            r_remaining <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_ovf       <= 1'b0;
            r_trunc     <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_ovf       <= n_ovf;
            r_trunc     <= n_trunc;
        end
    end

    assign o_status.dead      = (r_phase == ledf_pkg::PH_DEAD);
    assign o_status.in_header = (r_phase == ledf_pkg::PH_HEADER);

endmodule

[rtl/length_prefixed_event_deframer.sv]
// ============================================================================
// length_prefixed_event_deframer - byte stream to event fields
// Path: a byte accepted into the input byte register passes through the parser
// core into the result register, which holds its result beat.
// Throughput: one byte per cycle while the consumer is ready, set by the
// single-pass parser core between the input and result registers.
// Reset: synchronous, active low; the parser returns to the length field and
// both registers empty. After a format fault only reset revives the parser.
// ============================================================================
module length_prefixed_event_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Received byte stream.
    input  logic        i_data_valid,
    output logic        o_data_ready,
    input  logic [7:0]  i_data_byte,

    // Result beats, one per received byte.
    output logic        o_result_valid,
    input  logic        i_result_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_byte_is_json,
    output logic [63:0] o_callback_id,
    output logic        o_callback_valid,
    output logic        o_event_done,
    output logic        o_fatal_error
);

    // The input stage holds one byte. It hands that byte to the parser core
    // whenever the result register is empty or is being emptied in the same
    // cycle, so with a ready consumer the stream moves at one beat per cycle
    // and a stalled consumer backs up at most one byte in each register.
    logic                        in_valid;
    logic [ledf_pkg::BYTE_W-1:0] in_byte;
    logic                        advance;
    ledf_pkg::t_result           core_result;
    ledf_pkg::t_core_status      core_status;

    logic                        r_out_valid;
    logic                        n_out_valid;
    ledf_pkg::t_result           r_out;

    assign advance = in_valid && (!r_out_valid || i_result_ready);

    ledf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_data_valid),
        .i_byte  (i_data_byte),
        .o_ready (o_data_ready),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (advance)
    );

    // The core updates its parse state only on a step, and its result for
    // the byte in hand is captured in the result register on the same edge.
    ledf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (in_byte),
        .o_result (core_result),
        .o_status (core_status)
    );

    // Result register: filled on every step, emptied when the consumer takes
    // the beat and no new one replaces it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_result_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_valid     = r_out.byte_valid;
    assign o_byte_is_json   = r_out.byte_is_json;
    assign o_callback_id    = r_out.callback_id;
    assign o_callback_valid = r_out.callback_valid;
    assign o_event_done     = r_out.event_done;
    assign o_fatal_error    = r_out.fatal_error;

    // A fault beat carries nothing but the fault flag.
    a_fatal_alone : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_fatal_error) |->
        (!o_byte_valid && !o_callback_valid && !o_event_done && o_callback_id == '0))
        else $error("fault beat carries other fields");

    // Once the parser is dead, every byte it consumes yields an empty beat.
    a_dead_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_status.dead) |=>
        (o_result_valid && !o_byte_valid && !o_callback_valid &&
         !o_event_done && !o_fatal_error))
        else $error("dead parser produced a non-empty beat");

    // An event never completes while the length field is still being read.
    a_done_from_payload : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_status.in_header) |=> (!o_event_done && !o_byte_valid))
        else $error("length field byte produced payload output");

    // Back-pressure reaches the input only when both registers hold a beat.
    a_ready_backpressure : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_data_ready |-> (in_valid && r_out_valid && !i_result_ready))
        else $error("input stalled with room in the pipeline");

endmodule
